>>> rtl/static_loop_partition_defines.svh
// Assertion macros for the loop partition checker
`ifndef STATIC_LOOP_PARTITION_DEFINES_SVH
`define STATIC_LOOP_PARTITION_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// consequent checked in the cycle after the antecedent
`define SLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`endif

>>> rtl/slp_pkg.sv
// Shared types and constants of the static loop partition block
package slp_pkg;
  localparam int unsigned MaxThreadsDef = 16;
  localparam int unsigned DivW = 32;
  localparam logic [2:0] RegThreadCount = 3'd0;

  typedef struct packed {
    logic [31:0] lower_in;
    logic [31:0] upper_in;
    logic [31:0] step;
    logic [3:0]  thread_id;
    logic        unsigned_mode;
    logic        static_schedule;
  } req_t;

  typedef struct packed {
    logic [31:0] lower_out;
    logic [31:0] upper_out;
    logic        is_last;
    logic        last_written;
    logic [31:0] stride_out;
    logic        stride_written;
  } rsp_t;

  function automatic logic lt32(logic [31:0] a, logic [31:0] b, logic uns);
    logic [31:0] x;
    logic [31:0] y;
    x = uns ? a : (a ^ 32'h8000_0000);
    y = uns ? b : (b ^ 32'h8000_0000);
    return x < y;
  endfunction
endpackage

>>> rtl/slp_if.sv
// Valid/ready channel interfaces for requests and results
interface slp_req_if;
  import slp_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slp_rsp_if;
  import slp_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/slp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side-band tag
module slp_div import slp_pkg::*; #(
  parameter int unsigned TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     num_i,
  input  logic [31:0]     den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [31:0]     quo_o,
  output logic [31:0]     rem_o,
  output logic [TagW-1:0] tag_o
);
  logic [DivW:0]   vld_s;
  logic [31:0]     rem_s [DivW+1];
  logic [31:0]     quo_s [DivW+1];
  logic [31:0]     den_s [DivW+1];
  logic [TagW-1:0] tag_s [DivW+1];

  assign vld_s[0] = valid_i;
  assign rem_s[0] = '0;
  assign quo_s[0] = num_i;
  assign den_s[0] = den_i;
  assign tag_s[0] = tag_i;

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [32:0] r_sh;
    logic [33:0] diff;
    logic vld_q;
    logic [31:0] rem_q, quo_q, den_q;
    logic [TagW-1:0] tag_q;
    assign r_sh = {rem_s[s], quo_s[s][31]};
    assign diff = {1'b0, r_sh} - {2'b0, den_s[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[33]) begin
          rem_q <= diff[31:0];
          quo_q <= {quo_s[s][30:0], 1'b1};
        end else begin
          rem_q <= r_sh[31:0];
          quo_q <= {quo_s[s][30:0], 1'b0};
        end
        den_q <= den_s[s];
        tag_q <= tag_s[s];
      end
    end
    assign vld_s[s+1] = vld_q;
    assign rem_s[s+1] = rem_q;
    assign quo_s[s+1] = quo_q;
    assign den_s[s+1] = den_q;
    assign tag_s[s+1] = tag_q;
  end

  assign valid_o = vld_s[DivW];
  assign quo_o   = quo_s[DivW];
  assign rem_o   = rem_s[DivW];
  assign tag_o   = tag_s[DivW];
endmodule

>>> rtl/slp_front.sv
// Front stage: empty test, trip-count numerator and divisor selection
module slp_front import slp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  req_t        req_i,
  output logic        valid_o,
  output req_t        req_o,
  output logic        empty_o,
  output logic        pos_o,
  output logic [31:0] num_o,
  output logic [31:0] den_o
);
  logic pos, empty;
  logic [31:0] inc;
  assign inc = req_i.step;
  assign pos = (inc != '0) && !inc[31];
  assign empty = pos ? lt32(req_i.upper_in, req_i.lower_in, req_i.unsigned_mode)
                     : lt32(req_i.lower_in, req_i.upper_in, req_i.unsigned_mode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // unit steps need no bypass: a divide by one returns the numerator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_o   <= req_i;
      empty_o <= empty;
      pos_o   <= pos;
      num_o   <= pos ? (req_i.upper_in - req_i.lower_in)
                     : (req_i.lower_in - req_i.upper_in);
      den_o   <= pos ? inc : (32'd0 - inc);
    end
  end
endmodule

>>> rtl/slp_back.sv
// Back stages: chunk sizing, bound arithmetic, saturation and last flag
module slp_back import slp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  req_t        req_i,
  input  logic        empty_i,
  input  logic        pos_i,
  input  logic [31:0] trip_i,
  input  logic [31:0] cnt_i,
  input  logic [31:0] cquo_i,
  input  logic        cnz_i,
  output logic        valid_o,
  output rsp_t        rsp_o
);
  // stage A: choose path, compute chunk multiplicand
  logic        va_q;
  req_t        ra_q;
  logic        ea_q, pa_q, fewa_q, onea_q;
  logic [31:0] tripa_q, biga_q;
  logic [31:0] chunk;
  assign chunk = cquo_i + {31'd0, cnz_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q    <= req_i;
      ea_q    <= empty_i;
      pa_q    <= pos_i;
      onea_q  <= (cnt_i == 32'd1);
      fewa_q  <= trip_i < cnt_i;
      tripa_q <= trip_i;
      biga_q  <= chunk * req_i.step;
    end
  end

  // stage B: offset product
  logic        vb_q;
  req_t        rb_q;
  logic        eb_q, pb_q, fewb_q, oneb_q;
  logic [31:0] tripb_q, bigb_q, offb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rb_q    <= ra_q;
      eb_q    <= ea_q;
      pb_q    <= pa_q;
      oneb_q  <= onea_q;
      fewb_q  <= fewa_q;
      tripb_q <= tripa_q;
      bigb_q  <= biga_q;
      offb_q  <= {28'd0, ra_q.thread_id} * (fewa_q ? ra_q.step : biga_q);
    end
  end

  // stage C: sums, saturation and clamp
  logic [31:0] lo, hi, inc, olo, ohi, lim, nl, nh, str;
  logic        uns, last, lw, sw;
  always_comb begin
    lo  = rb_q.lower_in;
    hi  = rb_q.upper_in;
    inc = rb_q.step;
    uns = rb_q.unsigned_mode;
    olo = lo;
    ohi = hi;
    last = 1'b0;
    lw   = 1'b0;
    sw   = 1'b0;
    str  = '0;
    lim  = hi - inc;
    nl   = lo + offb_q;
    nh   = nl + bigb_q - inc;
    if (eb_q) begin
      lw = 1'b1; sw = 1'b1; str = inc;
    end else if (oneb_q) begin
      last = 1'b1; lw = 1'b1; sw = 1'b1;
      str = pb_q ? (hi - lo + 32'd1) : (32'd0 - (lo - hi + 32'd1));
    end else if (rb_q.static_schedule) begin
      lw = 1'b1;
      if (fewb_q) begin
        if ({28'd0, rb_q.thread_id} < tripb_q) begin
          olo = nl; ohi = nl;
        end else begin
          olo = hi + inc;
        end
        last = ({28'd0, rb_q.thread_id} == tripb_q - 32'd1);
      end else begin
        olo = nl;
        ohi = nh;
        if (pb_q) begin
          if (lt32(nh, nl, uns)) ohi = uns ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
          last = !lt32(hi, nl, uns) && lt32(lim, ohi, uns);
          if (lt32(hi, ohi, uns)) ohi = hi;
        end else begin
          if (lt32(nl, nh, uns)) ohi = uns ? 32'h0 : 32'h8000_0000;
          last = !lt32(nl, hi, uns) && lt32(ohi, lim, uns);
          if (lt32(ohi, hi, uns)) ohi = hi;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; valid_o <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i; vb_q <= va_q; valid_o <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_o <= '{lower_out: olo, upper_out: ohi, is_last: last, last_written: lw,
                 stride_out: str, stride_written: sw};
    end
  end
endmodule

>>> rtl/static_loop_partition.sv
// Top level of the static loop partition block
// Splits an inclusive loop range among the configured number of threads and
// returns one thread's sub-range, last-chunk flag and stride.
// Channels: req (lower, upper, step, thread id, mode, static flag) in, rsp out,
// valid/ready each; an APB-style port writes thread_count at address 0.
// Pipeline: one front stage, two 32-stage radix-2 dividers in series (trip
// count, then trip count over thread count), and three back stages for the
// chunk product, offset product and bounds.
// Throughput: one request per cycle while the receiver does not stall; the divider pipelines set the latency.
// Reset clears all valid bits and sets thread_count to 1.
// When the receiver stalls, the whole pipeline holds; the output register
// keeps its result and ready drops only while a result waits at the output.
// Ready upstream follows output ready or an empty output register.
module static_loop_partition import slp_pkg::*; #(
  parameter int unsigned MaxThreads = MaxThreadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slp_req_if.sink     req,
  slp_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned TagW = $bits(req_t) + 2;
  logic [4:0] tc_q;
  logic       en;
  logic [31:0] nth;

  assign pready = 1'b1;
  assign prdata = (paddr == RegThreadCount) ? {27'd0, tc_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= 5'd1;
    end else if (psel && penable && pwrite && paddr == RegThreadCount) begin
      tc_q <= pwdata[4:0];
    end
  end

  always_comb begin
    nth = {27'd0, tc_q};
    if (nth == '0) nth = 32'd1;
    if (nth > MaxThreads) nth = 32'(MaxThreads);
  end

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  logic        f_v, f_e, f_p;
  req_t        f_r;
  logic [31:0] f_n, f_d;
  slp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req.valid && en), .req_i(req.data),
    .valid_o(f_v), .req_o(f_r), .empty_o(f_e), .pos_o(f_p),
    .num_o(f_n), .den_o(f_d)
  );

  logic            d1_v;
  logic [31:0]     d1_q;
  logic [TagW-1:0] d1_t;
  slp_div #(.TagW(TagW)) u_div_trip (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .num_i(f_n), .den_i(f_d),
    .tag_i({f_r, f_e, f_p}), .valid_o(d1_v), .quo_o(d1_q), .rem_o(), .tag_o(d1_t)
  );

  logic [31:0] trip;
  assign trip = d1_q + 32'd1;

  localparam int unsigned Tag2W = TagW + 32;
  logic            d2_v;
  logic [31:0]     d2_q, d2_r;
  logic [Tag2W-1:0] d2_t;
  slp_div #(.TagW(Tag2W)) u_div_chunk (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_v), .num_i(trip), .den_i(nth),
    .tag_i({d1_t, trip}), .valid_o(d2_v), .quo_o(d2_q), .rem_o(d2_r), .tag_o(d2_t)
  );

  logic [31:0] trip2;
  req_t        r2;
  logic        e2, p2;
  assign trip2 = d2_t[31:0];
  assign {r2, e2, p2} = d2_t[Tag2W-1:32];

  slp_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_v), .req_i(r2), .empty_i(e2),
    .pos_i(p2), .trip_i(trip2), .cnt_i(nth), .cquo_i(d2_q), .cnz_i(d2_r != '0),
    .valid_o(rsp.valid), .rsp_o(rsp.data)
  );
endmodule

>>> rtl/slp_checker.sv
// Port-level checker for the static loop partition block, bound to the top
`include "static_loop_partition_defines.svh"
module slp_checker import slp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data,
  input logic pready
);
  `SLP_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_data))
  `SLP_ASSERT_IMP(a_rdy, clk_i, rst_ni, rsp_valid && !rsp_ready, !req_ready)
  `SLP_ASSERT_IMP(a_stride, clk_i, rst_ni, rsp_valid && !rsp_data.stride_written,
    rsp_data.stride_out == '0)
  `SLP_ASSERT_IMP(a_last, clk_i, rst_ni, rsp_valid && !rsp_data.last_written,
    !rsp_data.is_last)
  `SLP_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind static_loop_partition slp_checker u_slp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
  .pready(pready)
);

>>> tb/tb_static_loop_partition.sv
// Testbench for the static loop partition block: random and directed requests
module tb_static_loop_partition;
  timeunit 1ns;
  timeprecision 1ps;
  import slp_pkg::*;

  localparam int unsigned MaxThr = 16;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  slp_req_if req_ch ();
  slp_rsp_if rsp_ch ();

  static_loop_partition dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [4:0] thr_cfg = 5'd1;
  req_t pending_reqs[$];
  rsp_t expected_parts[$];
  int errors = 0;
  int sent = 0, got = 0;
  int src_gap = 0, snk_gap = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  function automatic bit ult(logic [31:0] a, logic [31:0] b, logic uns);
    if (!uns) begin
      a ^= 32'h8000_0000;
      b ^= 32'h8000_0000;
    end
    return a < b;
  endfunction

  function automatic rsp_t partition(req_t r, logic [4:0] cfg);
    rsp_t o;
    logic [31:0] lo, hi, inc, trip, nth, big, old_hi, lim, tid;
    logic pos, uns;
    lo = r.lower_in; hi = r.upper_in; inc = r.step; uns = r.unsigned_mode;
    tid = r.thread_id;
    pos = inc != 0 && !inc[31];
    nth = cfg == 0 ? 1 : (cfg > MaxThr ? MaxThr : cfg);
    o = '0;
    if (pos ? ult(hi, lo, uns) : ult(lo, hi, uns)) begin
      o.last_written = 1; o.stride_out = inc; o.stride_written = 1;
    end else if (nth == 1) begin
      o.is_last = 1; o.last_written = 1; o.stride_written = 1;
      o.stride_out = pos ? (hi - lo + 1) : (0 - (lo - hi + 1));
    end else begin
      if (inc == 1) trip = hi - lo + 1;
      else if (inc == 32'hFFFF_FFFF) trip = lo - hi + 1;
      else if (pos) trip = (hi - lo) / inc + 1;
      else if (inc == 0) trip = 32'hFFFF_FFFF + 1;  // divide by zero: all ones
      else trip = (lo - hi) / (0 - inc) + 1;
      if (r.static_schedule) begin
        o.last_written = 1;
        if (trip < nth) begin
          if (tid < trip) begin
            lo = lo + tid * inc;
            hi = lo;
          end else begin
            lo = hi + inc;
          end
          o.is_last = tid == trip - 1;
        end else begin
          big = (trip / nth + ((trip % nth) != 0)) * inc;
          old_hi = hi;
          lim = old_hi - inc;
          lo = lo + tid * big;
          hi = lo + big - inc;
          if (pos) begin
            if (ult(hi, lo, uns)) hi = uns ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
            o.is_last = !ult(old_hi, lo, uns) && ult(lim, hi, uns);
            if (ult(old_hi, hi, uns)) hi = old_hi;
          end else begin
            if (ult(lo, hi, uns)) hi = uns ? 32'h0 : 32'h8000_0000;
            o.is_last = !ult(lo, old_hi, uns) && ult(hi, lim, uns);
            if (ult(hi, old_hi, uns)) hi = old_hi;
          end
        end
      end
    end
    o.lower_out = lo;
    o.upper_out = hi;
    return o;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_parts.push_back(partition(req_ch.data, thr_cfg));
        sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.data <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e, a;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        a = rsp_ch.data;
        got++;
        if (expected_parts.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_parts.pop_front();
          if (a.lower_out !== e.lower_out) begin
            $error("lower_out exp %h got %h", e.lower_out, a.lower_out); errors++;
          end
          if (a.upper_out !== e.upper_out) begin
            $error("upper_out exp %h got %h", e.upper_out, a.upper_out); errors++;
          end
          if (a.is_last !== e.is_last) begin
            $error("is_last exp %b got %b", e.is_last, a.is_last); errors++;
          end
          if (a.last_written !== e.last_written) begin
            $error("last_written exp %b got %b", e.last_written, a.last_written); errors++;
          end
          if (a.stride_out !== e.stride_out) begin
            $error("stride_out exp %h got %h", e.stride_out, a.stride_out); errors++;
          end
          if (a.stride_written !== e.stride_written) begin
            $error("stride_written exp %b got %b", e.stride_written, a.stride_written);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 9);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_threads(input logic [4:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= RegThreadCount; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    thr_cfg = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_parts.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.lower_in = $urandom;
    r.thread_id = $urandom_range(0, 15);
    r.unsigned_mode = $urandom_range(0, 1);
    r.static_schedule = ($urandom_range(0, 7) != 0);
    k = $urandom_range(0, 9);
    case (k)
      0: r.step = $urandom;
      1: r.step = 0;
      2, 3: r.step = $urandom_range(1, 8);
      4: r.step = -$urandom_range(1, 8);
      default: r.step = $urandom_range(0, 1) ? 32'(1) : 32'hFFFF_FFFF;
    endcase
    k = $urandom_range(0, 4);
    if (k == 0) r.upper_in = $urandom;
    else if (r.step[31]) r.upper_in = r.lower_in - $urandom_range(0, 200);
    else r.upper_in = r.lower_in + $urandom_range(0, 200);
    if (k == 1) r.upper_in = r.lower_in + ($urandom >> $urandom_range(0, 31));
    return r;
  endfunction

  task automatic add(logic [31:0] lo, logic [31:0] hi, logic [31:0] st,
                     logic [3:0] tid, logic uns, logic stat);
    pending_reqs.push_back('{lo, hi, st, tid, uns, stat});
  endtask

  initial begin
    logic [4:0] cfgs[6] = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd7};
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (cfgs[c]) begin
      write_threads(cfgs[c]);
      if (c == 0 || c == 2) begin
        // directed corners: empty, zero step, wrap, extremes, ids beyond count
        add(0, 32'hFFFF_FFFF, 1, 0, 1, 1);
        add(0, 32'hFFFF_FFFF, 1, 15, 0, 1);
        add(32'h7FFF_FFFF, 32'h8000_0000, 1, 3, 0, 1);
        add(32'h7FFF_FFFF, 32'h8000_0000, 1, 3, 1, 1);
        add(10, 5, 1, 1, 0, 1);
        add(5, 10, -1, 1, 0, 1);
        add(5, 5, 0, 2, 0, 1);
        add(100, 0, 0, 4, 1, 1);
        add(0, 100, 32'h8000_0000, 1, 1, 1);
        add(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 9, 1, 1);
        add(0, 1000, 7, 5, 0, 0);
        add(0, 3, 1, 15, 1, 1);
        add(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1);
        add(32'h8000_0000, 32'h7FFF_FFFF, 3, 14, 0, 1);
        add(32'h7FFF_FFFF, 32'h8000_0000, -5, 6, 0, 1);
      end
      repeat (225) pending_reqs.push_back(rand_req());
      if (c == 5) quiet = 1;
      drain();
    end
    $display("Covered %0d requests over thread counts 0,1,3,7,16,31, %0d results checked",
             sent, got);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
